// ----- src/wrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wrc_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned THREADS_DEF = 4;

  localparam logic [31:0] ADDR_TOP = 32'hFFFF_FFFF;
  localparam logic [1:0] FLAG_WRITE = 2'd1;
  localparam logic [1:0] FLAG_READ = 2'd2;

  localparam logic [3:0] CMD_SET0 = 4'd0;
  localparam logic [3:0] CMD_SET3 = 4'd3;
  localparam logic [3:0] CMD_OR_READ = 4'd4;
  localparam logic [3:0] CMD_OR_WRITE = 4'd5;
  localparam logic [3:0] CMD_CLR_READ = 4'd6;
  localparam logic [3:0] CMD_CLR_WRITE = 4'd7;
  localparam logic [3:0] CMD_CHK_WRITE = 4'd8;
  localparam logic [3:0] CMD_CHK_READ = 4'd9;
  localparam logic [3:0] CMD_RESET = 4'd10;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD, OP_LOAD, OP_INS, OP_APPLY, OP_MARK, OP_SWAP, OP_WRITE, OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic        phase;
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] p;
  } cell_ctl_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] start;
    logic [1:0]  flag;
  } link_t;

  function automatic logic [1:0] flag_after(input logic [3:0] cmd, input logic [1:0] old);
    logic [1:0] r;
    case (cmd)
      CMD_OR_READ:   r = old | FLAG_READ;
      CMD_OR_WRITE:  r = old | FLAG_WRITE;
      CMD_CLR_READ:  r = old & ~FLAG_READ;
      CMD_CLR_WRITE: r = old & ~FLAG_WRITE;
      default:       r = cmd[1:0];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/wrc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wrc_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned THREADS = 4,
  parameter int unsigned TW = 2,
  parameter int unsigned CW = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wrc_pkg::cell_ctl_t ctl,
  input  wire logic [TW-1:0]     tsel,
  input  wire logic [CW-1:0]     cnt,
  input  wire wrc_pkg::link_t    lnk_l,
  input  wire logic              gt_l,
  input  wire wrc_pkg::link_t    lnk_r,
  output wrc_pkg::link_t         lnk,
  output logic                   gt,
  output logic                   eq,
  output logic                   hit
);
  import wrc_pkg::*;

  localparam bit FIRST = (IDX == 0);
  localparam bit PAR = (IDX % 2) == 1;

  link_t ld;
  logic [1:0] mask;

  generate
    if (IDX < ENTRIES) begin : g_store
      logic [31:0] st_start [THREADS];
      logic [1:0]  st_flag [THREADS];
      always_ff @(posedge clk) begin
        if (rst) begin
          if (FIRST) begin
            for (int t = 0; t < THREADS; t++) begin
              st_start[t] <= '0;
              st_flag[t] <= '0;
            end
          end
        end else if (ctl.op == OP_WRITE) begin
          st_start[tsel] <= lnk.start;
          st_flag[tsel] <= lnk.flag;
        end else if (ctl.op == OP_CLEAR && FIRST) begin
          st_start[tsel] <= '0;
          st_flag[tsel] <= '0;
        end
      end
      assign ld = '{valid: (32'(cnt) > IDX), start: st_start[tsel], flag: st_flag[tsel]};
    end else begin : g_spare
      assign ld = '{valid: 1'b0, start: '0, flag: '0};
    end
  endgenerate

  assign gt = lnk.valid && (lnk.start > ctl.p);
  assign eq = lnk.valid && (lnk.start == ctl.p);
  assign mask = (ctl.cmd == CMD_CHK_WRITE) ? FLAG_WRITE : FLAG_READ;
  assign hit = lnk.valid && ((lnk.flag & mask) != 2'b00) && (lnk.start <= ctl.b) &&
               (!lnk_r.valid || (lnk_r.start > ctl.a));

  always_ff @(posedge clk) begin
    if (rst) begin
      lnk.valid <= 1'b0;
    end else begin
      case (ctl.op)
        OP_LOAD: lnk <= ld;
        OP_INS: begin
          // shift up past the new boundary, or take it where it lands
          if (gt_l) begin
            lnk <= lnk_l;
          end else if (!FIRST && lnk_l.valid && (!lnk.valid || gt)) begin
            lnk <= '{valid: 1'b1, start: ctl.p, flag: lnk_l.flag};
          end
        end
        OP_APPLY: begin
          if (lnk.valid && lnk.start >= ctl.a && lnk.start <= ctl.b) begin
            lnk.flag <= flag_after(ctl.cmd, lnk.flag);
          end
        end
        OP_MARK: begin
          if (!FIRST && lnk.valid && lnk_l.valid && lnk.flag == lnk_l.flag) begin
            lnk.valid <= 1'b0;
          end
        end
        OP_SWAP: begin
          if (PAR == ctl.phase) begin
            if (!lnk.valid && lnk_r.valid) begin
              lnk <= lnk_r;
            end
          end else if (!FIRST && !lnk_l.valid && lnk.valid) begin
            lnk.valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/watch_range_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Watchpoint range cache, one sorted run-length list of address ranges per thread.
//
// Command channel: a transfer happens at a rising edge with start high and busy low;
// command, thread, lo_addr and hi_addr are sampled there.
// Result channel: done is high for exactly one cycle with hit, status and ranges_used;
// the receiver cannot stall, so nothing is ever held back.
//
// Results for reset thread, unknown command, bad thread and inverted range are registered
// at the accepting edge; a check (8/9) first loads the list into the row and then
// registers the hit; an edit (0..7) runs the steps below.
// An edit loads the list into a row of ENTRIES+2 cells, inserts up to two boundaries
// by shifting cells one place, rewrites flags, marks merged boundaries and then closes
// the gaps with ENTRIES+2 odd/even swap phases, then writes the list back unless it is full.
// A new command may be presented in the cycle that done is high.
//
// Reset (rst, synchronous) gives every thread one unwatched range starting at 0.
module watch_range_cache #(
  parameter int unsigned ENTRIES = wrc_pkg::ENTRIES_DEF,
  parameter int unsigned THREADS = wrc_pkg::THREADS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  command,
  input  wire logic [1:0]  thread,
  input  wire logic [31:0] lo_addr,
  input  wire logic [31:0] hi_addr,
  output logic             done,
  output logic             hit,
  output logic [1:0]       status,
  output logic [6:0]       ranges_used
);
  import wrc_pkg::*;

  localparam int unsigned M = ENTRIES + 2;               // cells in the row
  localparam int unsigned TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned PW = $clog2(M + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_INS_A, S_INS_B, S_APPLY, S_MARK, S_COMPACT, S_WRITE, S_CHECK
  } state_t;

  state_t state;
  logic [3:0]  cmd_q;
  logic [TW-1:0] t_q;
  logic [31:0] a_q, b_q;
  logic [PW-1:0] ph_cnt;
  logic [CW-1:0] count [THREADS];

  cell_ctl_t ctl;
  logic [TW-1:0] tsel;
  logic [CW-1:0] cnt_cur, cnt_new;
  logic thr_ok, accept, exists, hit_any, full;

  link_t lk [M];
  link_t lk_l [M];
  link_t lk_r [M];
  logic gt [M];
  logic gt_in [M];
  logic eqv [M];
  logic hitv [M];

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign thr_ok = (32'(thread) < THREADS);
  assign tsel = busy ? t_q : TW'(thread);
  assign cnt_cur = count[tsel];

  genvar j;
  generate
    for (j = 0; j < M; j++) begin : g_row
      if (j == 0) begin : g_lo
        assign lk_l[j] = '{valid: 1'b0, start: '0, flag: '0};
        assign gt_in[j] = 1'b0;
      end else begin : g_lm
        assign lk_l[j] = lk[j-1];
        assign gt_in[j] = gt[j-1];
      end
      if (j == M - 1) begin : g_hi
        assign lk_r[j] = '{valid: 1'b0, start: '0, flag: '0};
      end else begin : g_hm
        assign lk_r[j] = lk[j+1];
      end
      wrc_cell #(.IDX(j), .ENTRIES(ENTRIES), .THREADS(THREADS), .TW(TW), .CW(CW)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl), .tsel(tsel), .cnt(cnt_cur),
        .lnk_l(lk_l[j]), .gt_l(gt_in[j]), .lnk_r(lk_r[j]),
        .lnk(lk[j]), .gt(gt[j]), .eq(eqv[j]), .hit(hitv[j])
      );
    end
  endgenerate

  // reductions over the row: boundary already present, check hit, length after compaction
  always_comb begin
    exists = 1'b0;
    hit_any = 1'b0;
    cnt_new = '0;
    for (int i = 0; i < M; i++) begin
      exists = exists | eqv[i];
      hit_any = hit_any | hitv[i];
      if (lk[i].valid && !lk_r[i].valid) cnt_new = cnt_new | CW'(i + 1);
    end
  end
  assign full = lk[ENTRIES].valid;

  always_comb begin
    ctl.phase = ph_cnt[0];
    ctl.cmd = cmd_q;
    ctl.a = a_q;
    ctl.b = b_q;
    ctl.p = (state == S_INS_B) ? (b_q + 32'd1) : a_q;
    ctl.op = OP_HOLD;
    unique case (state)
      S_IDLE:    if (accept && thr_ok && command == CMD_RESET) ctl.op = OP_CLEAR;
      S_LOAD:    ctl.op = OP_LOAD;
      S_INS_A:   ctl.op = exists ? OP_HOLD : OP_INS;
      S_INS_B:   ctl.op = (exists || b_q == ADDR_TOP) ? OP_HOLD : OP_INS;
      S_APPLY:   ctl.op = OP_APPLY;
      S_MARK:    ctl.op = OP_MARK;
      S_COMPACT: ctl.op = OP_SWAP;
      S_WRITE:   ctl.op = full ? OP_HOLD : OP_WRITE;
      S_CHECK:   ctl.op = OP_HOLD;
      default:   ctl.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      for (int t = 0; t < THREADS; t++) count[t] <= CW'(1);
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= command;
            t_q <= TW'(thread);
            a_q <= lo_addr;
            b_q <= hi_addr;
            hit <= 1'b0;
            status <= ST_DONE;
            ranges_used <= 7'(cnt_cur);
            if (!thr_ok) begin
              done <= 1'b1;
              ranges_used <= '0;
            end else if (command == CMD_RESET) begin
              count[tsel] <= CW'(1);
              ranges_used <= 7'd1;
              done <= 1'b1;
            end else if (command <= CMD_CHK_READ && lo_addr > hi_addr) begin
              status <= ST_ORDER;
              done <= 1'b1;
            end else if (command <= CMD_CHK_READ) begin
              state <= S_LOAD;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_LOAD:  state <= (cmd_q <= CMD_CLR_WRITE) ? S_INS_A : S_CHECK;
        S_INS_A: state <= S_INS_B;
        S_INS_B: state <= S_APPLY;
        S_APPLY: state <= S_MARK;
        S_MARK: begin
          ph_cnt <= '0;
          state <= S_COMPACT;
        end
        S_COMPACT: begin
          if (ph_cnt == PW'(M - 1)) state <= S_WRITE;
          else ph_cnt <= ph_cnt + PW'(1);
        end
        S_WRITE: begin
          if (full) begin
            status <= ST_FULL;
            ranges_used <= 7'(cnt_cur);
          end else begin
            count[t_q] <= cnt_new;
            ranges_used <= 7'(cnt_new);
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_CHECK: begin
          hit <= hit_any;
          ranges_used <= 7'(cnt_cur);
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result always leaves the block ready for the next command
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  // a hit is only reported with status ST_DONE
  a_hit_ok: assert property (@(posedge clk) disable iff (rst) (done && hit) |-> status == ST_DONE)
    else $error("hit with non-zero status");
  // the list never loses its first range once work has begun
  a_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY || state == S_MARK || state == S_COMPACT) |-> lk[0].valid)
    else $error("first range lost");

endmodule
`default_nettype wire

// ----- tb/sv/watch_range_cache_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module watch_range_cache_tb;
  import wrc_pkg::*;

  localparam int unsigned ENTRIES = ENTRIES_DEF;
  localparam int unsigned THREADS = THREADS_DEF;
  localparam int NUM_RANDOM = 1600;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  command;
  logic [1:0]  thread;
  logic [31:0] lo_addr;
  logic [31:0] hi_addr;
  logic        done;
  logic        hit;
  logic [1:0]  status;
  logic [6:0]  ranges_used;

  watch_range_cache #(.ENTRIES(ENTRIES), .THREADS(THREADS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .thread(thread), .lo_addr(lo_addr), .hi_addr(hi_addr),
    .done(done), .hit(hit), .status(status), .ranges_used(ranges_used)
  );

  // One expected result per accepted command.
  typedef struct {
    logic       hit;
    logic [1:0] status;
    logic [6:0] ranges_used;
  } answer_t;

  answer_t answer_q[$];
  int errors = 0;
  int n_done = 0;
  int n_full = 0;
  int n_hits = 0;

  // Shadow of the per-thread range lists.
  logic [31:0] shadow_start[THREADS][ENTRIES];
  logic [1:0]  shadow_flag[THREADS][ENTRIES];
  int          shadow_count[THREADS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run (every command an edit, plus gaps).
  initial begin
    #(64'd40_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void shadow_clear();
    for (int t = 0; t < THREADS; t++) begin
      shadow_start[t][0] = '0;
      shadow_flag[t][0] = '0;
      shadow_count[t] = 1;
    end
  endfunction

  function automatic logic [1:0] edited_flag(logic [3:0] cmd, logic [1:0] old);
    logic [1:0] r;
    case (cmd)
      CMD_OR_READ:   r = old | FLAG_READ;
      CMD_OR_WRITE:  r = old | FLAG_WRITE;
      CMD_CLR_READ:  r = old & ~FLAG_READ;
      CMD_CLR_WRITE: r = old & ~FLAG_WRITE;
      default:       r = cmd[1:0];
    endcase
    return r;
  endfunction

  // Predicts the result of one command and updates the shadow lists.
  function automatic answer_t predict_command(logic [3:0] cmd, logic [1:0] t,
                                              logic [31:0] a, logic [31:0] b);
    answer_t r;
    logic [31:0] ns[ENTRIES];
    logic [1:0]  nf[ENTRIES];
    int nn;
    bit over;
    logic [32:0] e;
    logic [31:0] s;
    logic [1:0] old;
    logic [31:0] st[3];
    logic [1:0] fl[3];
    int k;
    r.hit = 1'b0;
    r.status = ST_DONE;
    nn = 0;
    over = 0;
    if (t >= THREADS) begin
      r.ranges_used = '0;
      return r;
    end
    if (cmd == CMD_RESET) begin
      shadow_start[t][0] = '0;
      shadow_flag[t][0] = '0;
      shadow_count[t] = 1;
    end else if (cmd <= CMD_CHK_READ && a > b) begin
      r.status = ST_ORDER;
    end else if (cmd <= CMD_CLR_WRITE) begin
      for (int i = 0; i < shadow_count[t]; i++) begin
        s = shadow_start[t][i];
        old = shadow_flag[t][i];
        e = (i + 1 < shadow_count[t]) ? {1'b0, shadow_start[t][i+1]} - 33'd1
                                      : {1'b0, ADDR_TOP};
        k = 0;
        if (e < {1'b0, a} || s > b) begin
          st[k] = s; fl[k] = old; k++;
        end else begin
          if (s < a) begin
            st[k] = s; fl[k] = old; k++;
          end
          st[k] = (s > a) ? s : a; fl[k] = edited_flag(cmd, old); k++;
          if (e > {1'b0, b}) begin
            st[k] = b + 32'd1; fl[k] = old; k++;
          end
        end
        // merge equal neighbours, flag overflow
        for (int j = 0; j < k; j++) begin
          if (nn > 0 && nf[nn-1] == fl[j]) continue;
          if (nn >= ENTRIES) begin
            over = 1;
            continue;
          end
          ns[nn] = st[j];
          nf[nn] = fl[j];
          nn++;
        end
      end
      if (over) begin
        r.status = ST_FULL;
      end else begin
        for (int i = 0; i < nn; i++) begin
          shadow_start[t][i] = ns[i];
          shadow_flag[t][i] = nf[i];
        end
        shadow_count[t] = nn;
      end
    end else if (cmd == CMD_CHK_WRITE || cmd == CMD_CHK_READ) begin
      for (int i = 0; i < shadow_count[t]; i++) begin
        s = shadow_start[t][i];
        e = (i + 1 < shadow_count[t]) ? {1'b0, shadow_start[t][i+1]} - 33'd1
                                      : {1'b0, ADDR_TOP};
        if (e >= {1'b0, a} && s <= b &&
            (shadow_flag[t][i] & ((cmd == CMD_CHK_WRITE) ? FLAG_WRITE : FLAG_READ)) != 0)
          r.hit = 1'b1;
      end
    end
    r.ranges_used = shadow_count[t][6:0];
    return r;
  endfunction

  // Result side: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    answer_t x;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with none expected (hit %0d status %0d used %0d)",
                 $time, hit, status, ranges_used);
        errors++;
      end else begin
        x = answer_q.pop_front();
        if (hit !== x.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, x.hit, hit);
          errors++;
        end
        if (status !== x.status) begin
          $display("%0t: status expected %0d actual %0d", $time, x.status, status);
          errors++;
        end
        if (ranges_used !== x.ranges_used) begin
          $display("%0t: ranges_used expected %0d actual %0d", $time, x.ranges_used,
                   ranges_used);
          errors++;
        end
        n_done++;
        if (status == ST_FULL) n_full++;
        if (hit) n_hits++;
      end
    end
  end

  // Presents one command at the falling edge, holds it until the transfer.
  task automatic send_command(logic [3:0] cmd, logic [1:0] t, logic [31:0] a,
                              logic [31:0] b, bit typed, answer_t want);
    answer_t p;
    command <= cmd;
    thread <= t;
    lo_addr <= a;
    hi_addr <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    p = predict_command(cmd, t, a, b);
    if (typed && (p.hit !== want.hit || p.status !== want.status ||
                  p.ranges_used !== want.ranges_used)) begin
      $display("%0t: table row disagrees, expected %0d/%0d/%0d predicted %0d/%0d/%0d",
               $time, want.hit, want.status, want.ranges_used, p.hit, p.status,
               p.ranges_used);
      errors++;
    end
    answer_q.insert(answer_q.size(), typed ? want : p);
    @(negedge clk);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 10)) @(negedge clk);
  endtask

  // Directed rows; typed answers only where obvious.
  typedef struct {
    logic [3:0]  cmd;
    logic [1:0]  t;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    logic        hit;
    logic [1:0]  st;
    logic [6:0]  used;
  } row_t;

  row_t rows[] = '{
    '{CMD_CHK_WRITE, 2'd0, 32'h0, ADDR_TOP, 1, 0, ST_DONE, 7'd1},
    '{CMD_CHK_READ, 2'd3, 32'h0, ADDR_TOP, 1, 0, ST_DONE, 7'd1},
    '{CMD_SET3, 2'd0, 32'h0, ADDR_TOP, 1, 0, ST_DONE, 7'd1},
    '{CMD_CHK_WRITE, 2'd0, ADDR_TOP, ADDR_TOP, 1, 1, ST_DONE, 7'd1},
    '{CMD_SET0, 2'd0, 32'h10, 32'h1F, 1, 0, ST_DONE, 7'd3},
    '{CMD_SET0, 2'd0, 32'h20, 32'h10, 1, 0, ST_ORDER, 7'd3},
    '{CMD_CHK_READ, 2'd0, 32'h5, 32'h4, 1, 0, ST_ORDER, 7'd3},
    '{4'd1, 2'd1, 32'h0, 32'h0, 1, 0, ST_DONE, 7'd2},
    '{4'd2, 2'd1, ADDR_TOP, ADDR_TOP, 1, 0, ST_DONE, 7'd3},
    '{CMD_OR_READ, 2'd1, 32'h100, 32'h1FF, 0, 0, ST_DONE, 7'd0},
    '{CMD_OR_WRITE, 2'd1, 32'h180, 32'h2FF, 0, 0, ST_DONE, 7'd0},
    '{CMD_CLR_READ, 2'd1, 32'h0, 32'h17F, 0, 0, ST_DONE, 7'd0},
    '{CMD_CLR_WRITE, 2'd1, 32'h200, ADDR_TOP, 0, 0, ST_DONE, 7'd0},
    '{CMD_CHK_READ, 2'd1, 32'h180, 32'h180, 0, 0, ST_DONE, 7'd0},
    '{CMD_CHK_WRITE, 2'd1, 32'h0, 32'h0, 0, 0, ST_DONE, 7'd0},
    '{4'd11, 2'd2, 32'h5, 32'h1, 1, 0, ST_DONE, 7'd1},
    '{4'd15, 2'd2, ADDR_TOP, 32'h0, 1, 0, ST_DONE, 7'd1},
    '{CMD_RESET, 2'd0, ADDR_TOP, 32'h0, 1, 0, ST_DONE, 7'd1},
    '{CMD_RESET, 2'd1, 32'h0, ADDR_TOP, 1, 0, ST_DONE, 7'd1},
    '{CMD_SET3, 2'd2, 32'h55AA_55AA, 32'hAA55_AA55, 1, 0, ST_DONE, 7'd3}
  };

  // Picks an address: mostly near a few hot spots so edits overlap and fragment.
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ADDR_TOP - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return {2'($urandom_range(0, 3)), 30'h0} | $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    answer_t want;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] tmp;
    logic [3:0] cmd;
    int wait_cycles;
    rst = 1'b1;
    start = 1'b0;
    command = '0;
    thread = '0;
    lo_addr = '0;
    hi_addr = '0;
    shadow_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      want.hit = rows[i].hit;
      want.status = rows[i].st;
      want.ranges_used = rows[i].used;
      send_command(rows[i].cmd, rows[i].t, rows[i].a, rows[i].b, rows[i].typed, want);
      if ($urandom_range(0, 2) == 0) idle_burst();
    end

    // Random phase: mostly ordered ranges and edits, so lists grow to fill the table.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      a = pick_addr();
      b = ($urandom_range(0, 3) == 0) ? pick_addr() : a + $urandom_range(0, 40);
      if (b < a && $urandom_range(0, 7) != 0) begin
        tmp = a; a = b; b = tmp;
      end
      case ($urandom_range(0, 19))
        0: cmd = CMD_RESET;
        1: cmd = 4'($urandom_range(11, 15));
        2, 3, 4: cmd = ($urandom_range(0, 1)) ? CMD_CHK_WRITE : CMD_CHK_READ;
        default: cmd = 4'($urandom_range(0, 7));
      endcase
      want = '{1'b0, 2'd0, 7'd0};
      send_command(cmd, 2'($urandom_range(0, 3)), a, b, 0, want);
      if (n < NUM_RANDOM - 200 && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (answer_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (ENTRIES + 20) @(posedge clk);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, answer_q.size());
      errors++;
    end
    $display("Ran %0d commands (%0d directed), %0d results checked,", rows.size() + NUM_RANDOM,
             rows.size(), n_done);
    $display("of which %0d hit a watched bit and %0d found the table full.", n_hits, n_full);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
